FILE: design/sip_pkg.sv
// sip_pkg: shared widths, codes and types of the spectral index pixel unit
// no dependencies; compile first
`timescale 1ns / 1ps

package sip_pkg;

  // sample and fixed point format
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 33;

  // divider sizing: divisor up to 3*(max-min), dividend up to (20*n) << frac
  localparam int DEN_W = SAMPLE_BITS + 2;
  localparam int NUM_W = SAMPLE_BITS + 6 + FRAC_BITS;
  localparam int N_W   = SAMPLE_BITS + 4;
  localparam int VAL_W = NUM_W + 2;

  // blend sum 9c + 7t - 4m and its divide by twenty via reciprocal
  localparam int TLI_W     = FRAC_BITS + 7;
  localparam int RCP_SHIFT = FRAC_BITS + 10;
  localparam int RCP_W     = RCP_SHIFT - 3;
  localparam int PROD_W    = TLI_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_20 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd20 + 64'd1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OUT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VAL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_THR   = 3'd3;
  localparam logic signed [OUT_W-1:0] WATER_THR_RST = 33'sd13107;

  // band positions in the sample vector and mask
  localparam int BAND_RED   = 0;
  localparam int BAND_GREEN = 1;
  localparam int BAND_BLUE  = 2;
  localparam int BAND_NIR   = 3;
  localparam int BAND_SWIR  = 4;
  localparam int BAND_EDGE  = 5;

  typedef enum logic [3:0] {
    MODE_NDVI  = 4'd0,
    MODE_NDWI  = 4'd1,
    MODE_NDBI  = 4'd2,
    MODE_MNDWI = 4'd3,
    MODE_NDMI  = 4'd4,
    MODE_NDCI  = 4'd5,
    MODE_NDTI  = 4'd6,
    MODE_TSS   = 4'd7,
    MODE_TLI   = 4'd8,
    MODE_FUI   = 4'd9,
    MODE_PC    = 4'd10,
    MODE_CDOM  = 4'd11
  } mode_t;

  typedef logic [SAMPLE_BITS-1:0] samp_t;

  typedef struct packed {
    samp_t [5:0] s;
    logic  [5:0] mask;
  } pix_t;

  typedef struct packed {
    mode_t                    mode;
    logic                     nodata_en;
    logic [15:0]              nodata_val;
    logic signed [OUT_W-1:0]  water_thr;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic neg;
    logic ok;
    logic add_one;
  } lane_tag_t;

  typedef struct packed {
    lane_tag_t        tag;
    logic [NUM_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] index_value;
    logic                    index_valid;
    logic                    above_threshold;
  } result_t;

endpackage

FILE: design/sip_ifs.sv
// sip_in_if / sip_out_if: valid-ready channels of the spectral index unit
// depends on nothing; field widths are those of the pixel and result beats
`timescale 1ns / 1ps

interface sip_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_sample;
  logic [15:0] green_sample;
  logic [15:0] blue_sample;
  logic [15:0] nir_sample;
  logic [15:0] swir_sample;
  logic [15:0] edge_sample;
  logic [5:0]  band_present_mask;

  modport source (output valid, red_sample, green_sample, blue_sample, nir_sample,
                  swir_sample, edge_sample, band_present_mask, input ready);
  modport sink   (input valid, red_sample, green_sample, blue_sample, nir_sample,
                  swir_sample, edge_sample, band_present_mask, output ready);
endinterface

interface sip_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] index_value;
  logic               index_valid;
  logic               above_threshold;

  modport source (output valid, index_value, index_valid, above_threshold, input ready);
  modport sink   (input valid, index_value, index_valid, above_threshold, output ready);
endinterface

FILE: design/spectral_index_pixel_top.sv
// spectral_index_pixel_top: per pixel normalized difference index unit
// depends on sip_pkg, sip_ifs, sip_front, sip_div_lane, sip_back
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | six band samples and the band present mask
//   out_ch   | out | index_value (Q16.16), index_valid, above_threshold
//   cfg_*    | in  | write enable, register index, data (no read-back)
//
// one pixel per clock unless out_ch stalls; the path is 3 front stages, 38 divider stages (one
//   quotient bit each, three lanes side by side), 2 back stages and the
//   output register, from accept to result
// in_ch.ready = !out_ch.valid || out_ch.ready; a stall freezes every stage
// rst_n is synchronous: clears all stage valid bits and the configuration registers
`timescale 1ns / 1ps

module spectral_index_pixel_top (
  input  logic                               clk,
  input  logic                               rst_n,
  sip_in_if.sink                             in_ch,
  sip_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [sip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sip_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  sip_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= sip_pkg::MODE_NDVI;
      cfg_r.nodata_en  <= 1'b0;
      cfg_r.nodata_val <= '0;
      cfg_r.water_thr  <= sip_pkg::WATER_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sip_pkg::CFG_INDEX_MODE: cfg_r.mode       <= sip_pkg::mode_t'(cfg_wdata[3:0]);
        sip_pkg::CFG_NODATA_EN:  cfg_r.nodata_en  <= cfg_wdata[0];
        sip_pkg::CFG_NODATA_VAL: cfg_r.nodata_val <= cfg_wdata[15:0];
        sip_pkg::CFG_WATER_THR:  cfg_r.water_thr  <= $signed(cfg_wdata[sip_pkg::OUT_W-1:0]);
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being drained
  logic adv, out_vld;
  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;

  // input beat packing
  sip_pkg::pix_t pix;
  assign pix.s[sip_pkg::BAND_RED]   = in_ch.red_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.s[sip_pkg::BAND_GREEN] = in_ch.green_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.s[sip_pkg::BAND_BLUE]  = in_ch.blue_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.s[sip_pkg::BAND_NIR]   = in_ch.nir_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.s[sip_pkg::BAND_SWIR]  = in_ch.swir_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.s[sip_pkg::BAND_EDGE]  = in_ch.edge_sample[sip_pkg::SAMPLE_BITS-1:0];
  assign pix.mask                   = in_ch.band_present_mask;

  // front end
  logic                req_vld;
  sip_pkg::div_req_t   req_a, req_b, req_c;
  sip_pkg::lane_tag_t  tag_a, tag_b, tag_c;

  sip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_ch.valid),
    .pix     (pix),
    .cfg     (cfg_r),
    .req_vld (req_vld),
    .req_a   (req_a),
    .req_b   (req_b),
    .req_c   (req_c),
    .tag_a   (tag_a),
    .tag_b   (tag_b),
    .tag_c   (tag_c)
  );

  // three divider lanes
  logic              vld_a, vld_b, vld_c;
  sip_pkg::div_res_t res_a, res_b, res_c;

  sip_div_lane u_div_a (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(req_vld),
    .req(req_a), .tag(tag_a), .out_vld(vld_a), .res(res_a)
  );

  sip_div_lane u_div_b (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(req_vld),
    .req(req_b), .tag(tag_b), .out_vld(vld_b), .res(res_b)
  );

  sip_div_lane u_div_c (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(req_vld),
    .req(req_c), .tag(tag_c), .out_vld(vld_c), .res(res_c)
  );

  // back end and output register
  sip_pkg::result_t result;

  sip_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (vld_a && vld_b && vld_c),
    .res_a   (res_a),
    .res_b   (res_b),
    .res_c   (res_c),
    .cfg     (cfg_r),
    .out_vld (out_vld),
    .result  (result)
  );

  assign out_ch.valid           = out_vld;
  assign out_ch.index_value     = result.index_value;
  assign out_ch.index_valid     = result.index_valid;
  assign out_ch.above_threshold = result.above_threshold;

`ifndef SYNTHESIS
  // divider lanes move in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_a == vld_b) && (vld_a == vld_c))
    else $error("divider lane valid bits disagree");

  // an invalid index always reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.index_valid) |-> (out_ch.index_value == '0))
    else $error("invalid index with nonzero value");

  // water flag only on a valid index
  a_flag_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.above_threshold) |-> out_ch.index_valid)
    else $error("threshold flag without valid index");

  // unused modes never give a valid index
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (cfg_r.mode > sip_pkg::MODE_CDOM)) |-> !out_ch.index_valid)
    else $error("valid index from an unused mode");

  // hue scale never falls below 1.0
  a_fui_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.index_valid && (cfg_r.mode == sip_pkg::MODE_FUI))
      |-> (out_ch.index_value >= (33'sd1 <<< sip_pkg::FRAC_BITS)))
    else $error("hue scale below one");
`endif

endmodule

FILE: design/sip_front.sv
// sip_front: sample validity, operand selection and divider request build
// three register stages; uses sip_pkg types and constants
`timescale 1ns / 1ps

module sip_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  sip_pkg::pix_t     pix,
  input  sip_pkg::cfg_t     cfg,
  output logic              req_vld,
  output sip_pkg::div_req_t req_a,
  output sip_pkg::div_req_t req_b,
  output sip_pkg::div_req_t req_c,
  output sip_pkg::lane_tag_t tag_a,
  output sip_pkg::lane_tag_t tag_b,
  output sip_pkg::lane_tag_t tag_c
);

  typedef enum logic [1:0] {
    FC_RED_GB = 2'd0,
    FC_RED_BG = 2'd1,
    FC_GREEN  = 2'd2,
    FC_BLUE   = 2'd3
  } fcase_t;

  // normalized difference request: |a-b| << frac over a+b
  function automatic sip_pkg::div_req_t nd_req(input sip_pkg::samp_t a,
                                               input sip_pkg::samp_t b);
    sip_pkg::div_req_t r;
    sip_pkg::samp_t    mag;
    mag   = (a >= b) ? (a - b) : (b - a);
    r.num = sip_pkg::NUM_W'(mag) << sip_pkg::FRAC_BITS;
    r.den = sip_pkg::DEN_W'(a) + sip_pkg::DEN_W'(b);
    return r;
  endfunction

  // ---- stage 1: capture samples and per band validity
  logic                  v1_r;
  sip_pkg::samp_t [5:0]  s1_r;
  logic [5:0]            ok1_r;
  logic [5:0]            ok1_nxt;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ok1_nxt[i] = pix.mask[i] &&
                   !(cfg.nodata_en && (32'(pix.s[i]) == 32'(cfg.nodata_val)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
    end
    if (adv) begin
      s1_r  <= pix.s;
      ok1_r <= ok1_nxt;
    end
  end

  // ---- stage 2: pick lane a pair, hue ordering and spread
  logic           v2_r;
  sip_pkg::samp_t a2_r, b2_r, r2_r, g2_r, b_2_r, sw2_r, d2_r;
  logic           oka2_r, okrg2_r, okgs2_r, rgb2_r;
  fcase_t         fc2_r;

  sip_pkg::samp_t a2_nxt, b2_nxt, mx, mn;
  logic           oka2_nxt, red_max;
  fcase_t         fc2_nxt;
  sip_pkg::samp_t r1, g1, bl1;

  assign r1  = s1_r[sip_pkg::BAND_RED];
  assign g1  = s1_r[sip_pkg::BAND_GREEN];
  assign bl1 = s1_r[sip_pkg::BAND_BLUE];

  // lane a operand pair per mode
  always_comb begin
    unique case (cfg.mode)
      sip_pkg::MODE_NDVI: begin
        a2_nxt = s1_r[sip_pkg::BAND_NIR];   b2_nxt = r1;
        oka2_nxt = ok1_r[sip_pkg::BAND_NIR] && ok1_r[sip_pkg::BAND_RED];
      end
      sip_pkg::MODE_NDWI: begin
        a2_nxt = g1;                        b2_nxt = s1_r[sip_pkg::BAND_NIR];
        oka2_nxt = ok1_r[sip_pkg::BAND_GREEN] && ok1_r[sip_pkg::BAND_NIR];
      end
      sip_pkg::MODE_NDBI: begin
        a2_nxt = s1_r[sip_pkg::BAND_SWIR];  b2_nxt = s1_r[sip_pkg::BAND_NIR];
        oka2_nxt = ok1_r[sip_pkg::BAND_SWIR] && ok1_r[sip_pkg::BAND_NIR];
      end
      sip_pkg::MODE_MNDWI: begin
        a2_nxt = g1;                        b2_nxt = s1_r[sip_pkg::BAND_SWIR];
        oka2_nxt = ok1_r[sip_pkg::BAND_GREEN] && ok1_r[sip_pkg::BAND_SWIR];
      end
      sip_pkg::MODE_NDMI: begin
        a2_nxt = s1_r[sip_pkg::BAND_NIR];   b2_nxt = s1_r[sip_pkg::BAND_SWIR];
        oka2_nxt = ok1_r[sip_pkg::BAND_NIR] && ok1_r[sip_pkg::BAND_SWIR];
      end
      sip_pkg::MODE_NDCI, sip_pkg::MODE_PC, sip_pkg::MODE_TLI: begin
        a2_nxt = s1_r[sip_pkg::BAND_EDGE];  b2_nxt = r1;
        oka2_nxt = ok1_r[sip_pkg::BAND_EDGE] && ok1_r[sip_pkg::BAND_RED];
      end
      sip_pkg::MODE_NDTI: begin
        a2_nxt = r1;                        b2_nxt = g1;
        oka2_nxt = ok1_r[sip_pkg::BAND_RED] && ok1_r[sip_pkg::BAND_GREEN];
      end
      sip_pkg::MODE_CDOM: begin
        a2_nxt = g1;                        b2_nxt = bl1;
        oka2_nxt = ok1_r[sip_pkg::BAND_GREEN] && ok1_r[sip_pkg::BAND_BLUE];
      end
      default: begin
        a2_nxt = '0;                        b2_nxt = '0;
        oka2_nxt = 1'b0;
      end
    endcase
  end

  // hue: which band is largest, red checked first
  always_comb begin
    mx = r1;
    if (g1 > mx) mx = g1;
    if (bl1 > mx) mx = bl1;
    mn = r1;
    if (g1 < mn) mn = g1;
    if (bl1 < mn) mn = bl1;
    red_max = (r1 >= g1) && (r1 >= bl1);
    priority if (red_max && (g1 >= bl1)) fc2_nxt = FC_RED_GB;
    else if (red_max)                    fc2_nxt = FC_RED_BG;
    else if (g1 >= bl1)                  fc2_nxt = FC_GREEN;
    else                                 fc2_nxt = FC_BLUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      oka2_r  <= oka2_nxt;
      r2_r    <= r1;
      g2_r    <= g1;
      b_2_r   <= bl1;
      sw2_r   <= s1_r[sip_pkg::BAND_SWIR];
      d2_r    <= mx - mn;
      fc2_r   <= fc2_nxt;
      okrg2_r <= ok1_r[sip_pkg::BAND_RED] && ok1_r[sip_pkg::BAND_GREEN];
      okgs2_r <= ok1_r[sip_pkg::BAND_GREEN] && ok1_r[sip_pkg::BAND_SWIR];
      rgb2_r  <= ok1_r[sip_pkg::BAND_RED] && ok1_r[sip_pkg::BAND_GREEN] &&
                 ok1_r[sip_pkg::BAND_BLUE] && ((r1 | g1 | bl1) != '0);
    end
  end

  // ---- stage 3: build the three divider requests
  logic                  v3_r;
  sip_pkg::div_req_t     ra3_r, rb3_r, rc3_r;
  sip_pkg::lane_tag_t    ta3_r, tb3_r, tc3_r;
  sip_pkg::div_req_t     ra_nxt;
  sip_pkg::lane_tag_t    ta_nxt;

  logic signed [sip_pkg::N_W-1:0] rs, gs, bs, ds, d3, n_raw, n_cl;
  logic [sip_pkg::NUM_W-1:0]      n20;

  // hue numerator, clamped to [0, 3d]
  always_comb begin
    rs = $signed(sip_pkg::N_W'(r2_r));
    gs = $signed(sip_pkg::N_W'(g2_r));
    bs = $signed(sip_pkg::N_W'(b_2_r));
    ds = $signed(sip_pkg::N_W'(d2_r));
    d3 = (ds <<< 1) + ds;
    unique case (fc2_r)
      FC_RED_GB: n_raw = gs - bs - ds;
      FC_RED_BG: n_raw = gs - bs + (ds <<< 2) + ds;
      FC_GREEN:  n_raw = bs - rs + ds;
      FC_BLUE:   n_raw = rs - gs + d3;
    endcase
    priority if (n_raw < 0) n_cl = '0;
    else if (n_raw > d3)    n_cl = d3;
    else                    n_cl = n_raw;
    n20 = (sip_pkg::NUM_W'($unsigned(n_cl)) << 4) + (sip_pkg::NUM_W'($unsigned(n_cl)) << 2);
  end

  // lane a request per mode
  always_comb begin
    ra_nxt = nd_req(a2_r, b2_r);
    ta_nxt.neg     = a2_r < b2_r;
    ta_nxt.ok      = oka2_r && ((a2_r | b2_r) != '0);
    ta_nxt.add_one = 1'b0;
    unique case (cfg.mode)
      sip_pkg::MODE_TSS: begin
        ra_nxt.num     = sip_pkg::NUM_W'(r2_r) << sip_pkg::FRAC_BITS;
        ra_nxt.den     = sip_pkg::DEN_W'(g2_r);
        ta_nxt.neg     = 1'b0;
        ta_nxt.ok      = okrg2_r && (g2_r != '0);
      end
      sip_pkg::MODE_FUI: begin
        if (d2_r == '0) begin
          ra_nxt.num = '0;
          ra_nxt.den = sip_pkg::DEN_W'(1);
        end else begin
          ra_nxt.num = n20 << sip_pkg::FRAC_BITS;
          ra_nxt.den = sip_pkg::DEN_W'($unsigned(d3));
        end
        ta_nxt.neg     = 1'b0;
        ta_nxt.ok      = rgb2_r;
        ta_nxt.add_one = 1'b1;
      end
      default: begin
        ta_nxt.add_one = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      ra3_r <= ra_nxt;
      ta3_r <= ta_nxt;
      // lane b: turbidity pair, lane c: modified water pair (blend inputs)
      rb3_r <= nd_req(r2_r, g2_r);
      tb3_r <= '{neg: r2_r < g2_r, ok: okrg2_r && ((r2_r | g2_r) != '0), add_one: 1'b0};
      rc3_r <= nd_req(g2_r, sw2_r);
      tc3_r <= '{neg: g2_r < sw2_r, ok: okgs2_r && ((g2_r | sw2_r) != '0), add_one: 1'b0};
    end
  end

  assign req_vld = v3_r;
  assign req_a   = ra3_r;
  assign req_b   = rb3_r;
  assign req_c   = rc3_r;
  assign tag_a   = ta3_r;
  assign tag_b   = tb3_r;
  assign tag_c   = tc3_r;

endmodule

FILE: design/sip_div_lane.sv
// sip_div_lane: pipelined restoring divider, one quotient bit per stage
// uses sip_pkg request, tag and result types
`timescale 1ns / 1ps

module sip_div_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  sip_pkg::div_req_t  req,
  input  sip_pkg::lane_tag_t tag,
  output logic               out_vld,
  output sip_pkg::div_res_t  res
);

  localparam int AW = sip_pkg::DEN_W + sip_pkg::NUM_W;
  localparam int NS = sip_pkg::NUM_W;

  // remainder over dividend/quotient, shifted one bit each stage
  logic [AW-1:0]               acc_r [NS];
  logic [sip_pkg::DEN_W-1:0]   den_r [NS-1];
  sip_pkg::lane_tag_t          tag_r [NS];
  logic                        vld_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [AW-1:0]               acc_in;
    logic [sip_pkg::DEN_W-1:0]   den_in;
    sip_pkg::lane_tag_t          tag_in;
    logic                        vld_in;
    logic [AW:0]                 sh;
    logic [sip_pkg::DEN_W:0]     top;
    logic                        qbit;
    logic [sip_pkg::DEN_W:0]     rem;
    logic [AW-1:0]               acc_nxt;

    if (k == 0) begin : g_first
      assign acc_in = {{sip_pkg::DEN_W{1'b0}}, req.num};
      assign den_in = req.den;
      assign tag_in = tag;
      assign vld_in = in_vld;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    // trial subtract of the divisor from the partial remainder
    assign sh      = {acc_in, 1'b0};
    assign top     = sh[AW:NS];
    assign qbit    = top >= {1'b0, den_in};
    assign rem     = qbit ? (top - {1'b0, den_in}) : top;
    assign acc_nxt = {rem[sip_pkg::DEN_W-1:0], sh[NS-1:1], qbit};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
      if (adv) begin
        acc_r[k] <= acc_nxt;
        tag_r[k] <= tag_in;
      end
    end

    // divisor travels along; the last stage keeps none
    if (k < NS-1) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign res.quot = acc_r[NS-1][NS-1:0];
  assign res.tag  = tag_r[NS-1];

endmodule

FILE: design/sip_back.sv
// sip_back: sign, blend, saturation, threshold flag and output register
// uses sip_pkg; takes the three divider lane results
`timescale 1ns / 1ps

module sip_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  sip_pkg::div_res_t res_a,
  input  sip_pkg::div_res_t res_b,
  input  sip_pkg::div_res_t res_c,
  input  sip_pkg::cfg_t     cfg,
  output logic              out_vld,
  output sip_pkg::result_t  result
);

  localparam logic signed [sip_pkg::VAL_W-1:0] VMAX =
    $signed({{(sip_pkg::VAL_W-sip_pkg::OUT_W+1){1'b0}}, {(sip_pkg::OUT_W-1){1'b1}}});
  localparam logic signed [sip_pkg::VAL_W-1:0] VMIN =
    $signed({{(sip_pkg::VAL_W-sip_pkg::OUT_W+1){1'b1}}, {(sip_pkg::OUT_W-1){1'b0}}});

  // ---- stage b1: signed lane values and blend sum
  logic                              v1_r, ok1_r;
  logic signed [sip_pkg::VAL_W-1:0]  val1_r;
  logic signed [sip_pkg::TLI_W-1:0]  x1_r;

  logic [sip_pkg::VAL_W-1:0]         qa;
  logic signed [sip_pkg::VAL_W-1:0]  va;
  logic signed [sip_pkg::TLI_W-1:0]  ta, tb, tc, x_nxt;
  logic                              ok_nxt;

  always_comb begin
    qa = sip_pkg::VAL_W'(res_a.quot) +
         (res_a.tag.add_one ? (sip_pkg::VAL_W'(1) << sip_pkg::FRAC_BITS) : '0);
    va = res_a.tag.neg ? -$signed(qa) : $signed(qa);
    ta = $signed(va[sip_pkg::TLI_W-1:0]);
    tb = res_b.tag.neg ? -$signed(sip_pkg::TLI_W'(res_b.quot))
                       : $signed(sip_pkg::TLI_W'(res_b.quot));
    tc = res_c.tag.neg ? -$signed(sip_pkg::TLI_W'(res_c.quot))
                       : $signed(sip_pkg::TLI_W'(res_c.quot));
    x_nxt = (ta <<< 3) + ta + (tb <<< 3) - tb - (tc <<< 2);
    if (cfg.mode == sip_pkg::MODE_TLI) begin
      ok_nxt = res_a.tag.ok && res_b.tag.ok && res_c.tag.ok;
    end else begin
      ok_nxt = res_a.tag.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
    end
    if (adv) begin
      val1_r <= va;
      x1_r   <= x_nxt;
      ok1_r  <= ok_nxt;
    end
  end

  // ---- stage b2: magnitude times reciprocal of twenty
  logic                              v2_r, ok2_r, xneg2_r;
  logic signed [sip_pkg::VAL_W-1:0]  val2_r;
  logic [sip_pkg::PROD_W-1:0]        prod2_r;
  logic [sip_pkg::TLI_W-1:0]         xmag;

  assign xmag = x1_r[sip_pkg::TLI_W-1] ? $unsigned(-x1_r) : $unsigned(x1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      val2_r  <= val1_r;
      ok2_r   <= ok1_r;
      xneg2_r <= x1_r[sip_pkg::TLI_W-1];
      prod2_r <= sip_pkg::PROD_W'(xmag) * sip_pkg::PROD_W'(sip_pkg::RCP_20);
    end
  end

  // ---- stage b3: mode select, zero when invalid, saturate, threshold
  logic [sip_pkg::TLI_W-1:0]         tq;
  logic signed [sip_pkg::TLI_W-1:0]  tli;
  logic signed [sip_pkg::VAL_W-1:0]  sel;
  logic signed [sip_pkg::OUT_W-1:0]  sat;
  sip_pkg::result_t                  res_nxt, res_r;
  logic                              vld_r;

  always_comb begin
    tq  = sip_pkg::TLI_W'(prod2_r >> sip_pkg::RCP_SHIFT);
    tli = xneg2_r ? -$signed(tq) : $signed(tq);
    if (!ok2_r) begin
      sel = '0;
    end else if (cfg.mode == sip_pkg::MODE_TLI) begin
      sel = sip_pkg::VAL_W'(tli);
    end else begin
      sel = val2_r;
    end
    priority if (sel > VMAX) sat = VMAX[sip_pkg::OUT_W-1:0];
    else if (sel < VMIN)     sat = VMIN[sip_pkg::OUT_W-1:0];
    else                     sat = sel[sip_pkg::OUT_W-1:0];
    res_nxt.index_value     = sat;
    res_nxt.index_valid     = ok2_r;
    res_nxt.above_threshold = ok2_r && (sat >= cfg.water_thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= v2_r;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r;
  assign result  = res_r;

endmodule
